/* rtl/padded_integer_to_ascii_defines.svh */
// Assertion macros shared by the checker of the padded integer to ASCII block.
// No dependencies; include by bare file name.
`ifndef PADDED_INTEGER_TO_ASCII_DEFINES_SVH
`define PADDED_INTEGER_TO_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define PIA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pia_pkg.sv */
// Package for the padded integer to ASCII block: constants, job type, helpers.
// No dependencies.
`timescale 1ns / 1ps

package pia_pkg;

  localparam int VALUE_W     = 64;
  localparam int DIGIT_W     = 4;
  localparam int MAX_DIGITS  = 20;
  localparam int MAX_OUTPUT  = 64;
  localparam int HEX_DIGITS  = VALUE_W / DIGIT_W;
  localparam int BCD_W       = MAX_DIGITS * DIGIT_W;
  // input bits folded into the BCD register per conversion cycle
  localparam int DABBLE_BITS = 4;
  localparam int CONV_CYCLES = VALUE_W / DABBLE_BITS;
  localparam int CNT_W       = $clog2(CONV_CYCLES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // radix codes
  localparam logic [1:0] MODE_DEC       = 2'd0;
  localparam logic [1:0] MODE_HEX_LOWER = 2'd1;
  localparam logic [1:0] MODE_HEX_UPPER = 2'd2;

  // character codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  // one formatted number waiting to be printed
  typedef struct packed {
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;  // least significant first
    logic [5:0]                         padn;    // pad characters
    logic [5:0]                         lead;    // padn + digit count - 1
    logic [5:0]                         total;   // characters to emit, >= 1
    logic [7:0]                         pad_char;
    logic                               upper;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < DIGIT_W'(10)) begin
      digit_char = CH_ZERO + {4'h0, d};
    end else begin
      digit_char = base + {4'h0, d} - 8'd10;
    end
  endfunction

endpackage

/* rtl/pia_num_if.sv */
// Input channel interface: one number plus its formatting controls per item.
// Depends on pia_pkg.
`timescale 1ns / 1ps

interface pia_num_if;
  import pia_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [1:0]         mode;
  logic               pad_zero;
  logic [5:0]         width;
  logic [6:0]         space;

  modport source (output valid, output value, output mode, output pad_zero,
                  output width, output space, input ready);
  modport sink   (input valid, input value, input mode, input pad_zero,
                  input width, input space, output ready);
endinterface

/* rtl/pia_text_if.sv */
// Output channel interface: one ASCII character per item.
// No dependencies.
`timescale 1ns / 1ps

interface pia_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/pia_front.sv */
// Front end: accepts a number, converts it to digits and sizes the field.
// Depends on pia_pkg and pia_num_if.
`timescale 1ns / 1ps

module pia_front
  import pia_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pia_num_if.sink       num,
  input  logic          queue_full,
  output logic          push,
  output job_t          job
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] shreg;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_next;
  logic [VALUE_W-1:0] shreg_next;
  logic               upper;
  logic               pad_zero;
  logic [5:0]         width;
  logic [6:0]         space;

  logic [4:0]         nd;
  logic [5:0]         nd6;
  logic [5:0]         longest;
  logic [6:0]         total7;
  logic               accept;

  assign num.ready = (state == ST_IDLE);
  assign accept    = num.valid && num.ready;

  // shift-add-3 conversion, DABBLE_BITS input bits per cycle
  always_comb begin
    logic [BCD_W-1:0]   b;
    logic [VALUE_W-1:0] v;
    b = bcd;
    v = shreg;
    for (int s = 0; s < DABBLE_BITS; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (b[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
          b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
        end
      end
      b = {b[BCD_W-2:0], v[VALUE_W-1]};
      v = {v[VALUE_W-2:0], 1'b0};
    end
    bcd_next   = b;
    shreg_next = v;
  end

  // significant digit count, at least one
  always_comb begin
    nd = 5'd1;
    for (int d = 1; d < MAX_DIGITS; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        nd = 5'(d + 1);
      end
    end
  end

  // field sizing
  always_comb begin
    nd6     = {1'b0, nd};
    longest = (width > nd6) ? width : nd6;
    total7  = {1'b0, longest};
    if (total7 > space) begin
      total7 = space;
    end
    if (total7 > 7'(MAX_OUTPUT)) begin
      total7 = 7'(MAX_OUTPUT);
    end
    job.digits   = bcd;
    job.padn     = (width > nd6) ? (width - nd6) : 6'd0;
    job.lead     = longest - 6'd1;
    job.total    = total7[5:0];
    job.pad_char = pad_zero ? CH_ZERO : CH_SPACE;
    job.upper    = upper;
  end

  assign push = (state == ST_PUSH) && (total7 != '0) && !queue_full;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= (num.mode == MODE_DEC) ? ST_CONV : ST_PUSH;
          end
        end
        ST_CONV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(CONV_CYCLES - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (total7 == '0 || !queue_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      upper    <= (num.mode != MODE_HEX_LOWER);
      pad_zero <= num.pad_zero;
      width    <= num.width;
      space    <= num.space;
      shreg    <= num.value;
      if (num.mode == MODE_DEC) begin
        bcd <= '0;
      end else begin
        bcd <= BCD_W'(num.value);
      end
    end else if (state == ST_CONV) begin
      bcd   <= bcd_next;
      shreg <= shreg_next;
    end
  end

endmodule

/* rtl/pia_queue.sv */
// Short job queue between front and back ends.
// Depends on pia_pkg.
`timescale 1ns / 1ps

module pia_queue
  import pia_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

/* rtl/pia_back.sv */
// Back end: walks the head job and emits one character per cycle while text is ready.
// Depends on pia_pkg and pia_text_if.
`timescale 1ns / 1ps

module pia_back
  import pia_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  pia_text_if.source text
);

  logic [5:0] pos;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;

  logic       advance;
  logic       is_last;
  logic [5:0] idx6;
  logic [4:0] idx;
  logic [7:0] ch;

  assign advance = head_valid && (!out_valid || text.ready);
  assign is_last = (pos + 6'd1) == head.total;
  assign pop     = advance && is_last;

  // padding first, then digits from the most significant down
  assign idx6 = head.lead - pos;
  assign idx  = idx6[4:0];
  assign ch   = (pos < head.padn) ? head.pad_char : digit_char(head.digits[idx], head.upper);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      // load on advance, clear once taken, hold while stalled
      out_valid <= advance || (out_valid && !text.ready);
      if (advance) begin
        pos <= is_last ? 6'd0 : pos + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= ch;
      out_last <= is_last;
    end
  end

  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;

endmodule

/* rtl/padded_integer_to_ascii.sv */
// Padded integer to ASCII: number in, one ASCII character per item out.
// Depends on pia_pkg, pia_num_if, pia_text_if, pia_front, pia_queue, pia_back.
//
// Channels: num takes value, mode, pad_zero, width and space; text gives
// character and last, last marking the final character of a number.
// An item with space of zero produces no characters.
// A hex item goes to the job queue straight after acceptance, a decimal item
// after shift-add-3 conversion, 4 bits at a time; each character then
// leaves through the back end's output register.
// Throughput: the front end takes a new number only after the last one is
// queued or, with space of zero, dropped; the back end emits one character
// per cycle while text is ready and a job is waiting.
// A two-entry job queue lets conversion run ahead while text is stalled.
// Reset clears the front state, the queue and the output register; no clearing
// pass is needed. A stalled receiver holds the character; the queue fills and
// num.ready stays low while the front end has a finished job it cannot place.
`timescale 1ns / 1ps

module padded_integer_to_ascii
  import pia_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pia_num_if.sink    num,
  pia_text_if.source text
);

  job_t front_job;
  job_t head_job;
  logic push;
  logic pop;
  logic queue_full;
  logic head_valid;

  pia_front u_front (
    .clk        (clk),
    .rst        (rst),
    .num        (num),
    .queue_full (queue_full),
    .push       (push),
    .job        (front_job)
  );

  pia_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_job     (front_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head_job)
  );

  pia_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head_job),
    .pop        (pop),
    .text       (text)
  );

endmodule

/* rtl/pia_checker.sv */
// Port-level checker for padded_integer_to_ascii, bound to the top level.
// Depends on padded_integer_to_ascii_defines.svh.
`timescale 1ns / 1ps
`include "padded_integer_to_ascii_defines.svh"

module pia_checker (
  input logic       clk,
  input logic       rst,
  input logic       num_valid,
  input logic       num_ready,
  input logic [6:0] num_space,
  input logic       text_valid,
  input logic       text_ready,
  input logic [7:0] text_character,
  input logic       text_last
);

  logic [2:0] pending;
  logic       num_take;
  logic       text_done;

  assign num_take  = num_valid && num_ready && (num_space != '0);
  assign text_done = text_valid && text_ready && text_last;

  // numbers accepted that still owe characters
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (num_take && !text_done) begin
      pending <= pending + 3'd1;
    end else if (text_done && !num_take && pending != '0) begin
      pending <= pending - 3'd1;
    end
  end

  `PIA_ASSERT_NEXT(a_valid_hold, clk, rst, (text_valid && !text_ready), (text_valid), "text valid dropped while stalled")
  `PIA_ASSERT_NEXT(a_char_hold, clk, rst, (text_valid && !text_ready), ($stable(text_character) && $stable(text_last)), "text payload changed while stalled")
  `PIA_ASSERT_NOW(a_no_orphan, clk, rst, (text_valid), (pending != '0), "character with no number outstanding")
  `PIA_ASSERT_NOW(a_char_set, clk, rst, (text_valid), (text_character == 8'h20 || (text_character >= 8'h30 && text_character <= 8'h39) || (text_character >= 8'h41 && text_character <= 8'h46) || (text_character >= 8'h61 && text_character <= 8'h66)), "character outside digit and pad set")

endmodule

bind padded_integer_to_ascii pia_checker u_pia_checker (
  .clk            (clk),
  .rst            (rst),
  .num_valid      (num.valid),
  .num_ready      (num.ready),
  .num_space      (num.space),
  .text_valid     (text.valid),
  .text_ready     (text.ready),
  .text_character (text.character),
  .text_last      (text.last)
);

/* sim/pia_text_checker.sv */
// Scoreboard for padded_integer_to_ascii: watches both channels, predicts the text.
// Depends on pia_pkg, pia_num_if and pia_text_if.
`timescale 1ns / 1ps

module pia_text_checker
  import pia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pia_num_if          num,
  pia_text_if         text,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t  chars_due[$];
  int unsigned mismatches = 0;

  // Render one number as padded text and queue its characters
  function automatic void format_number(input logic [VALUE_W-1:0] value,
                                        input logic [1:0] mode, input logic pad_zero,
                                        input logic [5:0] width, input logic [6:0] space);
    logic [7:0]         digit_text[MAX_DIGITS];
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] base;
    string              digit_set;
    logic [7:0]         pad_char;
    int                 nd;
    int                 padn;
    int                 total;
    int                 i;
    text_char_t         c;
    // mode 3 is not a radix of its own and renders as uppercase hex
    if (mode == MODE_DEC) begin
      digit_set = "0123456789";
      base = 64'd10;
    end else if (mode == MODE_HEX_LOWER) begin
      digit_set = "0123456789abcdef";
      base = 64'd16;
    end else begin
      digit_set = "0123456789ABCDEF";
      base = 64'd16;
    end
    // digits come out least significant first; zero still gives one digit
    rest = value;
    nd = 0;
    while (nd == 0 || rest != 0) begin
      digit_text[nd] = digit_set[int'(rest % base)];
      rest = rest / base;
      nd++;
    end
    pad_char = pad_zero ? CH_ZERO : CH_SPACE;
    padn = (int'(width) > nd) ? int'(width) - nd : 0;
    // free space caps the length: padding goes first, low digits are dropped
    total = padn + nd;
    if (total > int'(space)) total = int'(space);
    if (total > MAX_OUTPUT) total = MAX_OUTPUT;
    for (i = 0; i < total; i++) begin
      c.character = (i < padn) ? pad_char : digit_text[nd - 1 - (i - padn)];
      c.last = (i == total - 1);
      chars_due.push_back(c);
    end
  endfunction

  function automatic void note_failure(input text_char_t want, input text_char_t got,
                                       input logic nothing_due);
    if (mismatches < REPORT_LIMIT) begin
      if (nothing_due) begin
        $display("%0t: character %h last %b arrived with nothing due",
                 $time, got.character, got.last);
      end else begin
        $display("%0t: expected character %h last %b, got character %h last %b",
                 $time, want.character, want.last, got.character, got.last);
      end
    end
    mismatches++;
  endfunction

  // Predict on each accepted number, compare each accepted character
  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (!rst) begin
      if (num.valid && num.ready) begin
        format_number(num.value, num.mode, num.pad_zero, num.width, num.space);
      end
      if (text.valid && text.ready) begin
        got.character = text.character;
        got.last = text.last;
        if (chars_due.size() == 0) begin
          note_failure(got, got, 1'b1);
        end else begin
          want = chars_due.pop_front();
          if (got.character !== want.character || got.last !== want.last) begin
            note_failure(want, got, 1'b0);
          end
        end
      end
    end
    fail_count <= mismatches;
    outstanding <= chars_due.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for padded_integer_to_ascii: clock, reset, number stimulus,
// text back-pressure and the verdict. Depends on pia_pkg, the channel
// interfaces, the block and pia_text_checker.
`timescale 1ns / 1ps

module tb;
  import pia_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;  // renders as uppercase hex
  localparam int RESET_CYCLES    = 12;
  localparam int PHASE_ITEMS     = 88;
  localparam int BURST_ITEMS     = 20;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [1:0]         mode;
    logic               pad_zero;
    logic [5:0]         width;
    logic [6:0]         space;
  } number_t;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  int unsigned quiet_cycles;

  pia_num_if  num ();
  pia_text_if text ();

  padded_integer_to_ascii dut (
    .clk  (clk),
    .rst  (rst),
    .num  (num),
    .text (text)
  );

  pia_text_checker text_check (
    .clk         (clk),
    .rst         (rst),
    .num         (num),
    .text        (text),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one number; entered and left at a falling edge
  task automatic send_number(input logic [VALUE_W-1:0] value, input logic [1:0] mode,
                             input logic pad_zero, input logic [5:0] width,
                             input logic [6:0] space);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      num.valid <= 1'b0;
      @(negedge clk);
    end
    num.valid    <= 1'b1;
    num.value    <= value;
    num.mode     <= mode;
    num.pad_zero <= pad_zero;
    num.width    <= width;
    num.space    <= space;
    @(posedge clk);
    while (!num.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random number, weighted toward short values and a full output buffer
  function automatic number_t random_number();
    number_t     n;
    int unsigned pick;
    pick = $urandom_range(9, 0);
    n.value = {$urandom, $urandom};
    if (pick >= 4 && pick <= 6) n.value = n.value >> $urandom_range(63, 0);
    else if (pick == 7) n.value = VALUE_W'($urandom_range(20, 0));
    else if (pick == 8) n.value = {VALUE_W{1'b1}} >> $urandom_range(63, 0);
    else if (pick == 9) n.value = '0;
    pick = $urandom_range(9, 0);
    if (pick < 4) n.mode = MODE_DEC;
    else if (pick < 6) n.mode = MODE_HEX_LOWER;
    else if (pick < 9) n.mode = MODE_HEX_UPPER;
    else n.mode = MODE_UNUSED;
    n.pad_zero = 1'($urandom_range(1, 0));
    n.width = ($urandom_range(7, 0) == 0) ? 6'($urandom_range(63, 0))
                                          : 6'($urandom_range(24, 0));
    pick = $urandom_range(9, 0);
    if (pick < 6) n.space = 7'(MAX_OUTPUT);
    else if (pick < 9) n.space = 7'($urandom_range(MAX_OUTPUT, 0));
    else n.space = 7'($urandom_range(127, MAX_OUTPUT + 1));
    return n;
  endfunction

  // Text receiver: random stalls, plus one long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          text.ready <= 1'b0;
          @(negedge clk);
        end
      end
      text.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no item moving on either channel
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((num.valid && num.ready) || (text.valid && text.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    number_t n;
    int      phase;
    int      k;
    rst            = 1'b1;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    num.valid      = 1'b0;
    num.value      = '0;
    num.mode       = MODE_DEC;
    num.pad_zero   = 1'b0;
    num.width      = '0;
    num.space      = '0;
    text.ready     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every radix, truncation and empty output
    send_number(64'd0, MODE_DEC, 1'b0, 6'd0, 7'd64);
    send_number({VALUE_W{1'b1}}, MODE_DEC, 1'b0, 6'd0, 7'd64);
    send_number({VALUE_W{1'b1}}, MODE_HEX_LOWER, 1'b0, 6'd0, 7'd64);
    send_number({VALUE_W{1'b1}}, MODE_HEX_UPPER, 1'b1, 6'd0, 7'd64);
    send_number(64'hdead_beef_cafe_f00d, MODE_UNUSED, 1'b0, 6'd0, 7'd64);
    send_number(64'h0123_4567_89ab_cdef, MODE_HEX_LOWER, 1'b1, 6'd20, 7'd64);
    send_number(64'd12345, MODE_DEC, 1'b0, 6'd63, 7'd64);
    send_number(64'd42, MODE_DEC, 1'b1, 6'd63, 7'd127);
    send_number(64'd777, MODE_DEC, 1'b1, 6'd8, 7'd0);
    send_number(64'd123456789, MODE_DEC, 1'b1, 6'd12, 7'd5);
    send_number(64'd987654321, MODE_DEC, 1'b0, 6'd0, 7'd4);
    send_number(64'hfedc_ba98, MODE_HEX_UPPER, 1'b0, 6'd0, 7'd1);
    send_number(64'd10000000000000000000, MODE_DEC, 1'b0, 6'd0, 7'd64);
    send_number(64'd9999999999999999999, MODE_DEC, 1'b1, 6'd21, 7'd64);
    send_number(64'd255, MODE_HEX_LOWER, 1'b1, 6'd2, 7'd64);
    send_number(64'd1, MODE_DEC, 1'b0, 6'd1, 7'd1);
    send_number(64'd0, MODE_HEX_UPPER, 1'b1, 6'd63, 7'd63);
    send_number(64'ha, MODE_HEX_LOWER, 1'b0, 6'd5, 7'd3);
    send_number({VALUE_W{1'b1}}, MODE_DEC, 1'b1, 6'd40, 7'd127);

    // Random phases with different idle and stall mixes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // long receiver hold-off while numbers keep coming, to fill the queue
        if (phase == 0 && k == PHASE_ITEMS - BURST_ITEMS) hold_req = 1'b1;
        n = random_number();
        send_number(n.value, n.mode, n.pad_zero, n.width, n.space);
      end
    end
    num.valid <= 1'b0;
    recv_stall_pct = 0;

    // Drain, then allow for a late stray character
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pia_pkg.sv
rtl/pia_num_if.sv
rtl/pia_text_if.sv
rtl/pia_front.sv
rtl/pia_queue.sv
rtl/pia_back.sv
rtl/padded_integer_to_ascii.sv
rtl/pia_checker.sv
sim/pia_text_checker.sv
sim/tb.sv
